[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

[hdl/dupd_pkg.sv]
// ----------------------------------------------------------------------------
// dupd_pkg
// Types, character codes and lookup functions of the data URI payload decoder.
// ----------------------------------------------------------------------------
package dupd_pkg;

  localparam logic [7:0] CHAR_PCT    = 8'h25;
  localparam logic [7:0] CHAR_EQ     = 8'h3D;
  localparam logic [7:0] CHAR_DASH   = 8'h2D;
  localparam logic [7:0] CHAR_USCORE = 8'h5F;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } dupd_held_e;

  // One request from front to back: one to three results.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic            tail_blank;
    logic            stream_end;
    logic            bad_input;
  } dupd_entry_t;

  // {ok, 6-bit value}
  function automatic logic [6:0] b64_lookup(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      return {1'b1, d[5:0]};
    end
    if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      return {1'b1, d[5:0]};
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      return {1'b1, d[5:0]};
    end
    if (c == CHAR_PLUS || c == CHAR_DASH) return {1'b1, 6'd62};
    if (c == CHAR_SLASH || c == CHAR_USCORE) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  // {ok, 4-bit value}
  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

[hdl/dupd_front.sv]
// ----------------------------------------------------------------------------
// dupd_front
// Accepts payload characters, keeps decode state and builds one request of
// up to three results per character.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dupd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_mode_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  input  logic                  full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output dupd_pkg::dupd_entry_t entry_o
);
  import dupd_pkg::*;

  logic            mode_q;
  logic [11:0]     buf_q, buf_d;
  logic [2:0]      bits_q, bits_d;
  logic            err_q, err_d;
  dupd_held_e      held_q, held_d;
  logic [7:0]      hchar_q, hchar_d;

  logic            accept;
  logic [6:0]      b64;
  logic [4:0]      hx_c, hx_h;
  logic [3:0]      bsum;
  logic [11:0]     shifted;
  logic            ws, b64_take, is_pct;
  logic [1:0]      n;
  logic [3:0][7:0] bytes;
  logic            tail_blank, bad;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    b64      = b64_lookup(in_byte_i);
    hx_c     = hex_lookup(in_byte_i);
    hx_h     = hex_lookup(hchar_q);
    ws       = (in_byte_i == CHAR_SPACE) || (in_byte_i >= CHAR_TAB && in_byte_i <= CHAR_CR);
    b64_take = !err_q && !ws && (in_byte_i != CHAR_EQ);
    is_pct   = (in_byte_i == CHAR_PCT);
    bsum     = {1'b0, bits_q} + 4'd6;
    shifted  = '0;
    buf_d    = buf_q;
    bits_d   = bits_q;
    err_d    = err_q;
    held_d   = held_q;
    hchar_d  = hchar_q;
    n        = '0;
    bytes    = '0;
    tail_blank = 1'b0;
    bad      = 1'b0;

    if (!mode_q) begin
      if (b64_take) begin
        if (!b64[6]) begin
          err_d = 1'b1;
        end else begin
          buf_d = {buf_q[5:0], b64[5:0]};
          if (bsum >= 4'd8) begin
            bits_d   = 3'(bsum - 4'd8);
            shifted  = buf_d >> bits_d;
            bytes[0] = shifted[7:0];
            n        = 2'd1;
          end else begin
            bits_d = bsum[2:0];
          end
        end
      end
      if (in_last_i && n == 2'd0) begin
        n          = 2'd1;
        tail_blank = 1'b1;
      end
      bad = in_last_i && err_d;
    end else begin
      unique case (held_q)
        HELD_NONE: begin
          if (is_pct) begin
            held_d = HELD_PCT;
          end else begin
            bytes[n] = in_byte_i;
            n = n + 2'd1;
          end
        end
        HELD_PCT: begin
          if (hx_c[4]) begin
            held_d  = HELD_DIGIT;
            hchar_d = in_byte_i;
          end else begin
            bytes[n] = CHAR_PCT;
            n = n + 2'd1;
            if (is_pct) begin
              held_d = HELD_PCT;
            end else begin
              held_d = HELD_NONE;
              bytes[n] = in_byte_i;
              n = n + 2'd1;
            end
          end
        end
        HELD_DIGIT: begin
          held_d = HELD_NONE;
          if (hx_c[4]) begin
            bytes[n] = {hx_h[3:0], hx_c[3:0]};
            n = n + 2'd1;
          end else begin
            bytes[n] = CHAR_PCT;
            n = n + 2'd1;
            bytes[n] = hchar_q;
            n = n + 2'd1;
            if (is_pct) begin
              held_d = HELD_PCT;
            end else begin
              bytes[n] = in_byte_i;
              n = n + 2'd1;
            end
          end
        end
        default: held_d = HELD_NONE;
      endcase
      if (in_last_i) begin
        if (held_d != HELD_NONE) begin
          bytes[n] = CHAR_PCT;
          n = n + 2'd1;
        end
        if (held_d == HELD_DIGIT) begin
          bytes[n] = hchar_d;
          n = n + 2'd1;
        end
      end
    end

    // end of stream clears both modes
    if (in_last_i) begin
      buf_d   = '0;
      bits_d  = '0;
      err_d   = 1'b0;
      held_d  = HELD_NONE;
      hchar_d = '0;
    end
  end

  assign push_o             = accept && (n != 2'd0);
  assign entry_o.cnt        = n;
  assign entry_o.data       = bytes[2:0];
  assign entry_o.tail_blank = tail_blank;
  assign entry_o.stream_end = in_last_i;
  assign entry_o.bad_input  = bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      buf_q   <= '0;
      bits_q  <= '0;
      err_q   <= 1'b0;
      held_q  <= HELD_NONE;
      hchar_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
      if (accept) begin
        buf_q   <= buf_d;
        bits_q  <= bits_d;
        err_q   <= err_d;
        held_q  <= held_d;
        hchar_q <= hchar_d;
      end
    end
  end

  `ASSERT_CLK(a_end_clears, (accept && in_last_i) |=>
    (bits_q == 3'd0 && !err_q && held_q == HELD_NONE), "state not cleared after end item")
  `ASSERT_CLK(a_end_pushes, (accept && in_last_i) |-> push_o, "end item gave no result")

endmodule

[hdl/dupd_queue.sv]
// ----------------------------------------------------------------------------
// dupd_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dupd_queue #(
  parameter int Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dupd_pkg::dupd_entry_t entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output dupd_pkg::dupd_entry_t entry_o
);
  import dupd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dupd_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "pop from empty queue")

endmodule

[hdl/dupd_back.sv]
// ----------------------------------------------------------------------------
// dupd_back
// Takes requests from the queue and hands out their results one per cycle
// from the output register while out_stall_i is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dupd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  dupd_pkg::dupd_entry_t q_entry_i,
  output logic                  q_pop_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  byte_valid_o,
  output logic                  stream_end_o,
  output logic                  bad_input_o
);
  import dupd_pkg::*;

  dupd_entry_t cur_q;
  logic        vld_q;
  logic [1:0]  idx_q;
  logic        at_tail, out_take, load;

  assign at_tail  = (idx_q == cur_q.cnt - 2'd1);
  assign out_take = vld_q && !out_stall_i;
  assign load     = !vld_q || (out_take && at_tail);
  assign q_pop_o  = load && q_valid_i;

  always_comb begin
    unique case (idx_q)
      2'd0:    out_byte_o = cur_q.data[0];
      2'd1:    out_byte_o = cur_q.data[1];
      default: out_byte_o = cur_q.data[2];
    endcase
  end

  assign out_valid_o  = vld_q;
  assign byte_valid_o = !(cur_q.tail_blank && at_tail);
  assign stream_end_o = cur_q.stream_end && at_tail;
  assign bad_input_o  = cur_q.bad_input && at_tail;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load) begin
      vld_q <= q_valid_i;
      idx_q <= '0;
    end else if (out_take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  `ASSERT_CLK(a_cnt_nonzero, vld_q |-> (cur_q.cnt != 2'd0), "empty request in back")
  `ASSERT_CLK(a_idx_range, vld_q |-> (idx_q <= cur_q.cnt - 2'd1), "result index past request")

endmodule

[hdl/data_uri_payload_decoder_unit.sv]
// A character's first result passes through the request queue and then the output register.
// Throughput: one character per cycle while each gives at most one result and out_stall_i
// is low; a character with k results holds the single output register until all k are taken.
// Short bursts are absorbed by the QueueDepth-entry request queue.
// Reset clears decode state, mode (base64), queue and output valid.
// ----------------------------------------------------------------------------
// data_uri_payload_decoder_unit
// Base64 / percent decoder for data URI payloads, front, queue and back.
// ----------------------------------------------------------------------------
module data_uri_payload_decoder_unit #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       decode_mode_we_i,
  input  logic       decode_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       stream_end_o,
  output logic       bad_input_o
);
  import dupd_pkg::*;

  logic        push, pop, full, q_valid;
  dupd_entry_t f_entry, q_entry;

  dupd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (decode_mode_we_i),
    .cfg_mode_i (decode_mode_i),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .full_i     (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (f_entry)
  );

  dupd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  dupd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .stream_end_o (stream_end_o),
    .bad_input_o  (bad_input_o)
  );

endmodule
